// ===== design/pdc3_pkg.sv =====
// shared constants, widths, register codes and struct types for the three-form pd controller
// no dependencies; imported by pdc3_calc and pd_controller_three_form_top
package pdc3_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int FRAC_BITS      = 8;
   localparam int GAIN_WIDTH     = 16;
   localparam int DRIVE_WIDTH    = 32;
   localparam int MODE_WIDTH     = 2;

   localparam int ERR_WIDTH      = SAMPLE_WIDTH + 1;
   localparam int DIFF1_WIDTH    = SAMPLE_WIDTH + 2;
   localparam int STEP_Q_WIDTH   = 13;
   localparam int DIFF2_WIDTH    = (SAMPLE_WIDTH + 3 > STEP_Q_WIDTH + 1) ?
                                   SAMPLE_WIDTH + 3 : STEP_Q_WIDTH + 1;
   localparam int PROD_A_WIDTH   = GAIN_WIDTH + DIFF1_WIDTH;
   localparam int PROD_B_WIDTH   = GAIN_WIDTH + DIFF2_WIDTH;
   localparam int ACC_WIDTH      = PROD_B_WIDTH + 1;
   localparam int SHIFT_WIDTH    = ACC_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH      = ((SHIFT_WIDTH > DRIVE_WIDTH) ?
                                    SHIFT_WIDTH : DRIVE_WIDTH) + 1;

   localparam int STEP_LIMIT     = 8;
   localparam int DRIVE_LIMIT    = 255;

   localparam int REQ_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = DRIVE_WIDTH;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP        = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KD_PER_DT = 2'd2;

   localparam logic [MODE_WIDTH-1:0] MODE_POSITIONAL = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_VELOCITY   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MEASURE    = 2'd2;

   typedef struct packed {
      logic        [MODE_WIDTH-1:0]   mode;
      logic signed [GAIN_WIDTH-1:0]   kp;
      logic signed [GAIN_WIDTH-1:0]   kd_per_dt;
   } pdc3_cfg_type;

   typedef struct packed {
      logic signed [ERR_WIDTH-1:0]    err_now;
      logic signed [ERR_WIDTH-1:0]    err_prev;
      logic signed [DRIVE_WIDTH-1:0]  out_prev;
      logic signed [SAMPLE_WIDTH-1:0] setpoint_prev;
      logic signed [SAMPLE_WIDTH-1:0] measure_prev;
   } pdc3_hist_type;

endpackage

// ===== design/pdc3_calc.sv =====
// single-pass control law: three forms, gain products, rounding and saturation
// depends on pdc3_pkg
module pdc3_calc
   import pdc3_pkg::*;
(
   input  pdc3_cfg_type                   cfg,
   input  pdc3_hist_type                  hist,
   input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0] measurement,
   output logic signed [ERR_WIDTH-1:0]    err,
   output logic signed [DRIVE_WIDTH-1:0]  drive
);

   localparam logic signed [ERR_WIDTH-1:0] STEP_ROUND = ERR_WIDTH'((1 << FRAC_BITS) - 1);
   localparam logic signed [ERR_WIDTH-1:0] STEP_MAX   = ERR_WIDTH'(STEP_LIMIT);
   localparam logic signed [ERR_WIDTH-1:0] STEP_MIN   = -ERR_WIDTH'(STEP_LIMIT);
   localparam logic signed [ACC_WIDTH-1:0] ACC_ROUND  = ACC_WIDTH'((1 << (2 * FRAC_BITS)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] LIM_MAX    = ACC_WIDTH'(DRIVE_LIMIT);
   localparam logic signed [ACC_WIDTH-1:0] LIM_MIN    = -ACC_WIDTH'(DRIVE_LIMIT);
   localparam logic signed [DRIVE_WIDTH-1:0] DRV_MAX  = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
   localparam logic signed [DRIVE_WIDTH-1:0] DRV_MIN  = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

   logic signed [ERR_WIDTH-1:0]    sp_step;
   logic signed [ERR_WIDTH-1:0]    sp_step_int;
   logic signed [ERR_WIDTH-1:0]    sp_step_clamp;
   logic signed [ERR_WIDTH-1:0]    meas_step;
   logic signed [DIFF1_WIDTH-1:0]  diff1;
   logic signed [DIFF2_WIDTH-1:0]  diff2;
   logic signed [DIFF2_WIDTH-1:0]  meas_term;
   logic signed [DIFF1_WIDTH-1:0]  op_a;
   logic signed [DIFF2_WIDTH-1:0]  op_b;
   logic signed [PROD_A_WIDTH-1:0] prod_a;
   logic signed [PROD_B_WIDTH-1:0] prod_b;
   logic signed [ACC_WIDTH-1:0]    acc;
   logic signed [SHIFT_WIDTH-1:0]  acc_floor;
   logic signed [SUM_WIDTH-1:0]    sum_base;
   logic signed [SUM_WIDTH-1:0]    sum;
   logic signed [DRIVE_WIDTH-1:0]  drive_sat;
   logic signed [ACC_WIDTH-1:0]    acc_trunc;
   logic signed [ACC_WIDTH-1:0]    acc_clamp;
   logic signed [DRIVE_WIDTH-1:0]  drive_meas;
   logic                           is_velocity;
   logic                           is_measure;

   assign is_velocity = (cfg.mode == MODE_VELOCITY);
   assign is_measure  = (cfg.mode == MODE_MEASURE);

   assign err   = ERR_WIDTH'(setpoint) - ERR_WIDTH'(measurement);
   assign diff1 = DIFF1_WIDTH'(err) - DIFF1_WIDTH'(hist.err_now);
   assign diff2 = DIFF2_WIDTH'(err) - (DIFF2_WIDTH'(hist.err_now) <<< 1)
                  + DIFF2_WIDTH'(hist.err_prev);

   // setpoint step, truncated toward zero and clamped
   assign sp_step     = ERR_WIDTH'(setpoint) - ERR_WIDTH'(hist.setpoint_prev);
   assign sp_step_int = (sp_step < 0) ? ((sp_step + STEP_ROUND) >>> FRAC_BITS)
                                      : (sp_step >>> FRAC_BITS);
   always_comb begin
      priority if (sp_step_int > STEP_MAX) begin
         sp_step_clamp = STEP_MAX;
      end else if (sp_step_int < STEP_MIN) begin
         sp_step_clamp = STEP_MIN;
      end else begin
         sp_step_clamp = sp_step_int;
      end
   end
   assign meas_step = ERR_WIDTH'(measurement) - ERR_WIDTH'(hist.measure_prev);
   assign meas_term = (DIFF2_WIDTH'(sp_step_clamp) <<< FRAC_BITS) - DIFF2_WIDTH'(meas_step);

   assign op_a = is_velocity ? diff1 : DIFF1_WIDTH'(err);
   always_comb begin
      priority if (is_velocity) begin
         op_b = diff2;
      end else if (is_measure) begin
         op_b = meas_term;
      end else begin
         op_b = DIFF2_WIDTH'(diff1);
      end
   end

   assign prod_a = PROD_A_WIDTH'(cfg.kp) * PROD_A_WIDTH'(op_a);
   assign prod_b = PROD_B_WIDTH'(cfg.kd_per_dt) * PROD_B_WIDTH'(op_b);
   assign acc    = ACC_WIDTH'(prod_a) + ACC_WIDTH'(prod_b);

   // positional and velocity forms: floor to q.8, optional accumulate, saturate
   assign acc_floor = SHIFT_WIDTH'(acc >>> FRAC_BITS);
   assign sum_base  = is_velocity ? SUM_WIDTH'(hist.out_prev) : '0;
   assign sum       = sum_base + SUM_WIDTH'(acc_floor);
   always_comb begin
      priority if (sum > SUM_WIDTH'(DRV_MAX)) begin
         drive_sat = DRV_MAX;
      end else if (sum < SUM_WIDTH'(DRV_MIN)) begin
         drive_sat = DRV_MIN;
      end else begin
         drive_sat = DRIVE_WIDTH'(sum);
      end
   end

   // measurement form: truncate toward zero to an integer, clamp, back to q.8
   assign acc_trunc = (acc < 0) ? ((acc + ACC_ROUND) >>> (2 * FRAC_BITS))
                                : (acc >>> (2 * FRAC_BITS));
   always_comb begin
      priority if (acc_trunc > LIM_MAX) begin
         acc_clamp = LIM_MAX;
      end else if (acc_trunc < LIM_MIN) begin
         acc_clamp = LIM_MIN;
      end else begin
         acc_clamp = acc_trunc;
      end
   end
   assign drive_meas = DRIVE_WIDTH'(acc_clamp) <<< FRAC_BITS;

   assign drive = is_measure ? drive_meas : drive_sat;

endmodule

// ===== design/pd_controller_three_form_top.sv =====
// top level of the three-form pd controller: stream ports, control registers, history
// depends on pdc3_pkg and pdc3_calc
//
// One setpoint/measurement transaction in, one drive transaction out. A transaction can be
// accepted on every clock while the result register is empty or being drained. The input
// register loads it; the drive from one pass through both gain multiplies, the sum and the
// saturation goes into the result register when free. The controller history advances as
// each drive is registered, so back-to-back samples in velocity form see the previous drive
// at once. Mode 3 acts as positional PD. Control registers must be written through the csr
// port, which is always ready, only while idle; the block itself does not enforce this.
module pd_controller_three_form_top
   import pdc3_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // setpoint, measurement
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // drive
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic signed [SAMPLE_WIDTH-1:0] measurement_ff, measurement_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_WIDTH-1:0]  drive_ff, drive_in;
   pdc3_hist_type                  hist_ff, hist_in;
   pdc3_cfg_type                   cfg_ff, cfg_in;
   logic signed [ERR_WIDTH-1:0]    err;
   logic signed [DRIVE_WIDTH-1:0]  drive;
   logic                           advance;
   logic                           req_take;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   pdc3_calc u_calc (
      .cfg         (cfg_ff),
      .hist        (hist_ff),
      .setpoint    (setpoint_ff),
      .measurement (measurement_ff),
      .err         (err),
      .drive       (drive)
   );

   // input register
   always_comb begin
      in_valid_in    = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      setpoint_in    = req_take ? req_tdata[SAMPLE_WIDTH-1:0] : setpoint_ff;
      measurement_in = req_take ? req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : measurement_ff;
   end

   // result register and history
   always_comb begin
      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
      drive_in     = advance ? drive : drive_ff;
      hist_in      = hist_ff;
      if (advance) begin
         hist_in.err_prev      = hist_ff.err_now;
         hist_in.err_now       = err;
         hist_in.out_prev      = drive;
         hist_in.setpoint_prev = setpoint_ff;
         hist_in.measure_prev  = measurement_ff;
      end
   end

   // control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:      cfg_in.mode      = csr_data[MODE_WIDTH-1:0];
            CSR_KP:        cfg_in.kp        = csr_data[GAIN_WIDTH-1:0];
            CSR_KD_PER_DT: cfg_in.kd_per_dt = csr_data[GAIN_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      setpoint_ff    <= setpoint_in;
      measurement_ff <= measurement_in;
      drive_ff       <= drive_in;
   end

endmodule
